/* rtl/itrs_pkg.sv */
// Shared types, constants and the digit-to-ASCII mapping for the radix string unit.
package itrs_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;

  // Defaults for the top-level parameters
  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned MAX_DIGITS_DEF = 64;

  // Dividend bits consumed per divider cycle
  localparam int unsigned STEP_BITS = 8;

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd62;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // ASCII anchors
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_UPPER_FIRST = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_LOWER_FIRST = 6'd36;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ
  } state_e;

  // Divider control from the sequencer
  typedef struct packed {
    logic start;  // begin a new digit pass
    logic load;   // take the input value rather than the held quotient
  } div_ctrl_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic done;       // remainder valid this cycle
    logic quot_zero;  // quotient after this pass is zero
  } div_stat_t;

  // Digit value to ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_UPPER_FIRST) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < DIGIT_LOWER_FIRST) begin
      c = CHAR_UPPER + CHAR_W'(d - DIGIT_UPPER_FIRST);
    end else begin
      c = CHAR_LOWER + CHAR_W'(d - DIGIT_LOWER_FIRST);
    end
    return c;
  endfunction

endpackage

/* rtl/integer_to_radix_string_unit.sv */
// Top level: unsigned integer to ASCII digit string in a configurable radix.
//
// Input channel: value_i with in_valid_i / in_stall_o; a word is taken when valid
// is high and stall is low. Only the low VALUE_BITS bits of the value are used.
// Output channel: one word per digit (digit_char_o, last_digit_o), most significant
// first, with out_valid_o / out_stall_i. last_digit_o marks the final digit.
// Zero gives the single digit '0'; at most MAX_DIGITS low digits are produced.
// Configuration: cfg_radix_i is written on cfg_valid_i (cfg_ready_o is always high);
// the user must write it only while the unit is idle; the unit does not enforce this.
// Radix 0 or 1 acts as 2, radix 63 as 62.
// Timing: one item at a time. Each digit comes from the iterative divider,
// which handles 8 dividend bits a cycle. The digits are then read back from
// the digit store through its registered read data and the output register.
// The next item is taken once the last digit has been read from the store,
// while that digit may still wait in the output register.
// Reset returns the radix to 10 and empties the pipeline; the store needs no clearing.
// A stall on the output holds the current word and pauses the read-back.
module integer_to_radix_string_unit #(
  parameter int unsigned VALUE_BITS = itrs_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [itrs_pkg::RADIX_W-1:0]  cfg_radix_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [itrs_pkg::VALUE_W-1:0]  value_i,
  // output words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [itrs_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                          last_digit_o
);
  import itrs_pkg::*;

  localparam int unsigned PAD_W  = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_DIGITS);

  state_e               state_q, state_d;
  logic [RADIX_W-1:0]   radix_q;
  logic [RADIX_W-1:0]   radix_eff;
  logic [CNT_W-1:0]     count_q, count_d, count_inc;
  logic [ADDR_W-1:0]    rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]     rd_left_q, rd_left_d;
  logic                 rd_pend_q, rd_last_q;
  logic                 rd_issue, rd_last;
  logic                 out_valid_q, out_last_q;
  logic [CHAR_W-1:0]    out_char_q;
  logic                 out_take;
  logic                 in_take;
  logic [PAD_W-1:0]     value_pad;
  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;
  logic [DIGIT_W-1:0]   div_digit;
  logic                 mem_we;
  logic [DIGIT_W-1:0]   mem_rdata;

  // Radix register and clamping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_radix_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign radix_eff   = (radix_q < RADIX_MIN) ? RADIX_MIN :
                       (radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;

  assign value_pad = PAD_W'(value_i[VALUE_BITS-1:0]);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign out_take   = out_valid_q && !out_stall_i;
  assign count_inc  = count_q + CNT_W'(1);
  assign rd_last    = (rd_left_q == CNT_W'(1));

  // Sequencer: next state and controls
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rd_idx_d      = rd_idx_q;
    rd_left_d     = rd_left_q;
    div_ctrl      = '0;
    mem_we        = 1'b0;
    rd_issue      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          div_ctrl.start = 1'b1;
          div_ctrl.load  = 1'b1;
          count_d        = '0;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          mem_we  = 1'b1;
          count_d = count_inc;
          if (!div_stat.quot_zero && (count_inc < CNT_W'(MAX_DIGITS))) begin
            div_ctrl.start = 1'b1;
          end else begin
            rd_idx_d  = count_q[ADDR_W-1:0];
            rd_left_d = count_inc;
            state_d   = S_READ;
          end
        end
      end
      S_READ: begin
        if (!rd_pend_q && (!out_valid_q || out_take)) begin
          rd_issue  = 1'b1;
          rd_idx_d  = rd_idx_q - ADDR_W'(1);
          rd_left_d = rd_left_q - CNT_W'(1);
          if (rd_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_idx_q  <= '0;
      rd_left_q <= '0;
      rd_pend_q <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      rd_left_q <= rd_left_d;
      rd_pend_q <= rd_issue;
      if (rd_issue) begin
        rd_last_q <= rd_last;
      end
    end
  end

  // Output register, loaded as read data lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_pend_q) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      out_char_q <= digit_to_char(mem_rdata);
      out_last_q <= rd_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_digit_o = out_last_q;

  itrs_divider #(
    .PAD_W (PAD_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .value_i (value_pad),
    .radix_i (radix_eff),
    .stat_o  (div_stat),
    .digit_o (div_digit)
  );

  itrs_digit_mem #(
    .DEPTH  (MAX_DIGITS),
    .ADDR_W (ADDR_W)
  ) u_digit_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (div_digit),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q),
    .rdata_o (mem_rdata)
  );

  // A read issued in the cycle before always lands in the output register
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> out_valid_q)
    else $error("read data did not reach the output register");

  // No read may be in flight once a division run is under way
  a_div_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !rd_pend_q)
    else $error("read in flight during division");

  // Digit writes stay inside the store
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (count_q < CNT_W'(MAX_DIGITS)))
    else $error("digit write beyond store depth");

  // Read-back always has digits left to fetch
  a_read_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (rd_left_q != '0))
    else $error("read-back with no digits left");

  // The divider reports a digit only during division
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside division");

  // Input is taken only when the unit is idle, and a taken input starts a run with the count cleared
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == S_DIV) && (count_q == '0))
    else $error("input taken without starting a run");

endmodule

/* rtl/itrs_divider.sv */
// Iterative divider: divides the loaded value or the held quotient by the radix, STEP_BITS bits per cycle.
module itrs_divider #(
  parameter int unsigned PAD_W = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itrs_pkg::div_ctrl_t           ctrl_i,
  input  logic [PAD_W-1:0]              value_i,
  input  logic [itrs_pkg::RADIX_W-1:0]  radix_i,
  output itrs_pkg::div_stat_t           stat_o,
  output logic [itrs_pkg::DIGIT_W-1:0]  digit_o
);
  import itrs_pkg::*;

  localparam int unsigned CHUNKS  = PAD_W / STEP_BITS;
  localparam int unsigned CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic [PAD_W-1:0]     acc_q, acc_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic [CHUNK_W-1:0]   chunk_q;
  logic                 busy_q;
  logic [STEP_BITS-1:0] qbits;
  logic [DIGIT_W:0]     trial;
  logic                 last_chunk;

  // Restoring division over one chunk of dividend bits
  always_comb begin
    rem_d = rem_q;
    qbits = '0;
    trial = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_d, acc_q[PAD_W-1-i]};
      if (trial >= {1'b0, radix_i}) begin
        trial = trial - {1'b0, radix_i};
        qbits[STEP_BITS-1-i] = 1'b1;
      end
      rem_d = trial[DIGIT_W-1:0];
    end
    acc_d = (acc_q << STEP_BITS) | PAD_W'(qbits);
  end

  assign last_chunk     = busy_q && (chunk_q == CHUNK_W'(CHUNKS - 1));
  assign stat_o.done      = last_chunk;
  assign stat_o.quot_zero = (acc_d == '0);
  assign digit_o          = rem_d;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      chunk_q <= '0;
    end else if (ctrl_i.start) begin
      busy_q  <= 1'b1;
      chunk_q <= '0;
    end else if (busy_q) begin
      busy_q  <= !last_chunk;
      chunk_q <= chunk_q + CHUNK_W'(1);
    end
  end

  // Dividend / quotient and partial remainder
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && ctrl_i.load) begin
      acc_q <= value_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.start) begin
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
    end
  end

endmodule

/* rtl/itrs_digit_mem.sv */
// Digit store: one write port, one read port with registered read data.
module itrs_digit_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ADDR_W-1:0]             waddr_i,
  input  logic [itrs_pkg::DIGIT_W-1:0]  wdata_i,
  input  logic                          re_i,
  input  logic [ADDR_W-1:0]             raddr_i,
  output logic [itrs_pkg::DIGIT_W-1:0]  rdata_o
);
  import itrs_pkg::*;

  logic [DIGIT_W-1:0] mem_q [DEPTH];
  logic [DIGIT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/tb_integer_to_radix_string_unit.sv */
// Self-checking testbench for the integer to radix string unit.
`timescale 1ns / 1ps

module tb_integer_to_radix_string_unit;

  import itrs_pkg::*;

  localparam int unsigned VALUE_BITS   = 64;
  localparam int unsigned MAX_DIGITS   = 64;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned WORDS_PER_PHASE = 48;

  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);

  // ASCII anchors of the three digit ranges
  localparam logic [CHAR_W-1:0] ASCII_DIGIT0 = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_UPPER  = 7'd65;
  localparam logic [CHAR_W-1:0] ASCII_LOWER  = 7'd97;

  // Idle profiles: sender idles / receiver idles, in percent
  localparam int unsigned TX_IDLE_A = 27;
  localparam int unsigned RX_IDLE_A = 51;

  typedef struct {
    logic [CHAR_W-1:0] ascii;
    logic              is_last;
  } digit_word_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [RADIX_W-1:0]   cfg_radix_i  = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [VALUE_W-1:0]   value_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [CHAR_W-1:0]    digit_char_o;
  logic                 last_digit_o;

  logic [VALUE_W-1:0] pending_values [$];
  digit_word_t        expected_digits [$];

  logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
  int unsigned        values_queued = 0;
  int unsigned        values_sent = 0;
  int unsigned        values_taken = 0;
  int unsigned        tx_idle_pct = 0;
  int unsigned        rx_idle_pct = 0;
  int unsigned        err_count = 0;
  int unsigned        cycle_count = 0;

  integer_to_radix_string_unit #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_radix_i (cfg_radix_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .digit_char_o(digit_char_o),
    .last_digit_o(last_digit_o)
  );

  always #4 clk_i = ~clk_i;

  // Digit value to its ASCII code
  function automatic logic [CHAR_W-1:0] ascii_of_digit(input logic [DIGIT_W-1:0] d);
    if (d < 6'd10) begin
      return ASCII_DIGIT0 + CHAR_W'(d);
    end else if (d < 6'd36) begin
      return ASCII_UPPER + CHAR_W'(d - 6'd10);
    end
    return ASCII_LOWER + CHAR_W'(d - 6'd36);
  endfunction

  // Expected digit words of one value, most significant first
  function automatic void queue_radix_digits(input logic [VALUE_W-1:0] value,
                                             input logic [RADIX_W-1:0] setting);
    logic [VALUE_W-1:0] quotient;
    logic [VALUE_W-1:0] base;
    logic [DIGIT_W-1:0] digits [64];
    int                 n;
    digit_word_t        w;
    // out-of-range settings are clamped to 2 .. 62
    if (setting < 6'd2) begin
      base = 64'd2;
    end else if (setting > 6'd62) begin
      base = 64'd62;
    end else begin
      base = 64'(setting);
    end
    quotient = value & VALUE_MASK;
    n = 0;
    // zero still yields one digit; stop at the store depth
    do begin
      digits[n] = DIGIT_W'(quotient % base);
      quotient  = quotient / base;
      n++;
    end while (quotient != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      w.ascii   = ascii_of_digit(digits[k]);
      w.is_last = (k == 0);
      expected_digits.push_back(w);
    end
  endfunction

  // Mixed value shapes: zero, all ones, short and full-width randoms
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = VALUE_W'($urandom_range(255));
      3, 4: v = v >> $urandom_range(63);
      default: ;
    endcase
    return v;
  endfunction

  // Driver: input words and output stall change on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // a new word only once the previous one has been taken
      if (values_taken == values_sent) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          value_i    <= pending_values.pop_front();
          in_valid_i <= 1'b1;
          values_sent++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Monitor: track the radix, predict on each taken word, check each digit word
  always @(posedge clk_i) begin
    digit_word_t w;
    if (cfg_valid_i && cfg_ready_o) begin
      radix_setting = cfg_radix_i;
    end
    if (out_valid_o && !out_stall_i) begin
      if (expected_digits.size() == 0) begin
        $error("unexpected digit word: digit_char %0d last_digit %0d",
               digit_char_o, last_digit_o);
        err_count++;
      end else begin
        w = expected_digits.pop_front();
        if (digit_char_o !== w.ascii) begin
          $error("digit_char: expected %0d, got %0d", w.ascii, digit_char_o);
          err_count++;
        end
        if (last_digit_o !== w.is_last) begin
          $error("last_digit: expected %0d, got %0d", w.is_last, last_digit_o);
          err_count++;
        end
      end
    end
    if (in_valid_i && !in_stall_o) begin
      queue_radix_digits(value_i, radix_setting);
      values_taken++;
    end
  end

  // Timeout guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[integer_to_radix_string_unit] ERROR");
      $finish;
    end
  end

  // Waits until every value is taken and every digit word has come out
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (values_taken != values_queued || expected_digits.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Sequence: reset, then phases of radix setting and value words
  initial begin
    logic [RADIX_W-1:0] phase_radix [NUM_PHASES];
    logic [VALUE_W-1:0] directed [$];
    phase_radix = '{6'd62, 6'd10, 6'd0, 6'd16, 6'd1, 6'd63, 6'd2, 6'd36, 6'd37};
    phase_radix[NUM_PHASES-1] = RADIX_W'($urandom_range(3, 61));
    // radix 62 extremes: digit range edges, widths and bit patterns
    directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd35, 64'd36, 64'd61, 64'd62, 64'd3843,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 64'h0123_4567_89AB_CDEF};

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // radix write while the unit is idle
      cfg_radix_i <= phase_radix[p];
      cfg_valid_i <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!cfg_ready_o);
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);

      // idle profile: first thirds A, then swapped, then none
      if (p < NUM_PHASES / 3) begin
        tx_idle_pct = TX_IDLE_A;
        rx_idle_pct = RX_IDLE_A;
      end else if (p < 2 * NUM_PHASES / 3) begin
        tx_idle_pct = RX_IDLE_A;
        rx_idle_pct = TX_IDLE_A;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      if (p == 0) begin
        foreach (directed[i]) begin
          pending_values.push_back(directed[i]);
          values_queued++;
        end
      end
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        pending_values.push_back(random_value());
        values_queued++;
      end
      wait_idle();
    end

    if (expected_digits.size() != 0) begin
      $error("%0d digit words never arrived", expected_digits.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("[integer_to_radix_string_unit] OK");
    end else begin
      $display("[integer_to_radix_string_unit] ERROR");
    end
    $finish;
  end

endmodule
